// File: hdl/e2r_pkg.sv
// Package with the constants, types and helper functions of the Euler to rotation block.
package e2r_pkg;

   localparam int CordicSteps = 16;
   localparam int AngleW      = 16;
   localparam int OutW        = 16;
   localparam int DataW       = 32;

   localparam logic signed [AngleW:0] HalfTurn    = 17'sd23040;
   localparam logic signed [AngleW:0] FullTurn    = 17'sd46080;
   localparam logic        [14:0]     QuarterTurn = 15'd11520;
   // Pi in Q2.30 written as PiQuot * 23040 + PiRem.
   localparam logic        [17:0]     PiQuot      = 18'd146408;
   localparam logic        [14:0]     PiRem       = 15'd19106;
   // Reciprocal of 45 scaled by 2^25 (rounded up); exact for numerators below 2^19.
   localparam logic        [19:0]     Recip45     = 20'd745655;
   localparam logic signed [DataW:0]  CordicGain  = 33'sd652032874;
   localparam logic signed [DataW:0]  OneQ30      = 33'sd1073741824;
   localparam logic signed [OutW:0]   OutOne      = 17'sd16384;

   typedef logic signed [DataW:0] q30_type;
   typedef logic signed [AngleW-1:0] angle_type;
   typedef logic signed [OutW-1:0] entry_type;

   // Sine and cosine pair of one angle.
   typedef struct packed {
      q30_type c;
      q30_type s;
   } sincos_type;

   // Arctangent of 2^-i in Q2.30.
   function automatic q30_type atan_q30(input int i);
      q30_type t;
      case (i)
         0: t = 33'sd843314857;
         1: t = 33'sd497837829;
         2: t = 33'sd263043837;
         3: t = 33'sd133525159;
         4: t = 33'sd67021687;
         5: t = 33'sd33543516;
         6: t = 33'sd16775851;
         7: t = 33'sd8388437;
         8: t = 33'sd4194283;
         9: t = 33'sd2097149;
         default: t = (i < 31) ? q30_type'(33'sd1 <<< (30 - i)) : '0;
      endcase
      return t;
   endfunction

   // Q2.30 product with rounding to nearest, half up.
   function automatic q30_type qmul(input q30_type a, input q30_type b);
      logic signed [2*DataW+1:0] p;
      p = a * b + (66'sd1 <<< 29);
      return q30_type'(p >>> 30);
   endfunction

   // Rounding to Q1.14 with saturation to plus or minus one.
   function automatic entry_type to_out(input logic signed [DataW+2:0] v);
      logic signed [DataW+2:0] q;
      q = (v + 35'sd32768) >>> 16;
      if (q > 35'(OutOne)) q = 35'(OutOne);
      if (q < -35'(OutOne)) q = -35'(OutOne);
      return entry_type'(q);
   endfunction

endpackage

// File: hdl/e2r_sincos.sv
// Pipelined range reduction and rotation CORDIC for one angle.
module e2r_sincos (
   input  logic                 clock,
   input  logic                 en,
   input  e2r_pkg::angle_type   angle,
   output e2r_pkg::sincos_type  result
);
   import e2r_pkg::*;

   localparam int Stages = CordicSteps;

   logic [14:0]  mag_ff;
   logic         neg_s0_ff, neg_c0_ff;
   logic [30:0]  base_ff;
   logic [27:0]  num_ff;
   logic         neg_s1_ff, neg_c1_ff;
   q30_type      x_ff [Stages+1];
   q30_type      y_ff [Stages+1];
   q30_type      z_ff [Stages+1];
   logic         neg_s_ff [Stages+1];
   logic         neg_c_ff [Stages+1];
   sincos_type   result_ff;

   logic signed [AngleW:0] a_in;
   logic [AngleW:0] m_in;
   logic [14:0]  mag_in;
   logic         neg_c_in;
   logic [39:0]  recip_prod;
   logic [13:0]  quot;

   // Reduce to a half turn and fold into the first quadrant.
   always_comb begin
      a_in = AngleW'(0) + 17'(angle);
      if (a_in >= HalfTurn) a_in = a_in - FullTurn;
      if (a_in < -HalfTurn) a_in = a_in + FullTurn;
      m_in = (a_in < 0) ? 17'(-a_in) : 17'(a_in);
      neg_c_in = m_in > 17'(QuarterTurn);
      mag_in = neg_c_in ? 15'(17'(HalfTurn) - m_in) : m_in[14:0];
   end

   // Remainder part divided by 23040: a shift by 9, then an exact reciprocal of 45.
   always_comb begin
      recip_prod = 40'(num_ff[27:9]) * 40'(Recip45);
      quot = 14'(recip_prod >> 25);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
         neg_s0_ff <= a_in < 0;
         neg_c0_ff <= neg_c_in;
         base_ff <= 31'(mag_ff) * 31'(PiQuot);
         num_ff <= 28'(mag_ff) * 28'(PiRem) + 28'(QuarterTurn);
         neg_s1_ff <= neg_s0_ff;
         neg_c1_ff <= neg_c0_ff;
         x_ff[0] <= CordicGain;
         y_ff[0] <= '0;
         z_ff[0] <= q30_type'(33'(base_ff) + 33'(quot));
         neg_s_ff[0] <= neg_s1_ff;
         neg_c_ff[0] <= neg_c1_ff;
      end
   end

   // One CORDIC micro-rotation per stage.
   for (genvar i = 0; i < Stages; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][DataW]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_q30(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_q30(i);
            end
            neg_s_ff[i+1] <= neg_s_ff[i];
            neg_c_ff[i+1] <= neg_c_ff[i];
         end
      end
   end

   // Clamp to one and apply the fold signs.
   always_ff @(posedge clock) begin
      q30_type xc, yc;
      if (en) begin
         xc = x_ff[Stages];
         yc = y_ff[Stages];
         if (xc > OneQ30) xc = OneQ30;
         if (xc < -OneQ30) xc = -OneQ30;
         if (yc > OneQ30) yc = OneQ30;
         if (yc < -OneQ30) yc = -OneQ30;
         result_ff.c <= neg_c_ff[Stages] ? -xc : xc;
         result_ff.s <= neg_s_ff[Stages] ? -yc : yc;
      end
   end

   assign result = result_ff;
endmodule

// File: hdl/e2r_matrix.sv
// Pipelined product stages that form the nine rotation matrix entries.
module e2r_matrix (
   input  logic                 clock,
   input  logic                 en,
   input  e2r_pkg::sincos_type  roll,
   input  e2r_pkg::sincos_type  pitch,
   input  e2r_pkg::sincos_type  yaw,
   output e2r_pkg::entry_type   entry [9]
);
   import e2r_pkg::*;

   q30_type cysp_ff, sysp_ff, cycp_ff, sycp_ff, sycr_ff, sysr_ff, cycr_ff, cysr_ff;
   q30_type cpsr_ff, cpcr_ff, nsp_ff, sr_ff, cr_ff;
   q30_type p_ff [9];
   q30_type q_ff [9];
   entry_type out_ff [9];

   // First products.
   always_ff @(posedge clock) begin
      if (en) begin
         cysp_ff <= qmul(yaw.c, pitch.s);
         sysp_ff <= qmul(yaw.s, pitch.s);
         cycp_ff <= qmul(yaw.c, pitch.c);
         sycp_ff <= qmul(yaw.s, pitch.c);
         sycr_ff <= qmul(yaw.s, roll.c);
         sysr_ff <= qmul(yaw.s, roll.s);
         cycr_ff <= qmul(yaw.c, roll.c);
         cysr_ff <= qmul(yaw.c, roll.s);
         cpsr_ff <= qmul(pitch.c, roll.s);
         cpcr_ff <= qmul(pitch.c, roll.c);
         nsp_ff  <= -pitch.s;
         sr_ff   <= roll.s;
         cr_ff   <= roll.c;
      end
   end

   // Second products; the second term of each sum rides alongside.
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= cycp_ff;             q_ff[0] <= '0;
         p_ff[1] <= qmul(cysp_ff, sr_ff); q_ff[1] <= -sycr_ff;
         p_ff[2] <= qmul(cysp_ff, cr_ff); q_ff[2] <= sysr_ff;
         p_ff[3] <= sycp_ff;             q_ff[3] <= '0;
         p_ff[4] <= qmul(sysp_ff, sr_ff); q_ff[4] <= cycr_ff;
         p_ff[5] <= qmul(sysp_ff, cr_ff); q_ff[5] <= -cysr_ff;
         p_ff[6] <= nsp_ff;              q_ff[6] <= '0;
         p_ff[7] <= cpsr_ff;             q_ff[7] <= '0;
         p_ff[8] <= cpcr_ff;             q_ff[8] <= '0;
      end
   end

   // Sum, round and saturate.
   for (genvar k = 0; k < 9; k++) begin : g_out
      always_ff @(posedge clock) begin
         if (en) out_ff[k] <= to_out(35'(p_ff[k]) + 35'(q_ff[k]));
      end
      assign entry[k] = out_ff[k];
   end
endmodule

// File: hdl/euler_to_rotation_matrix_top.sv
// Top level of the ZYX Euler angle to rotation matrix block.
//
//  Channel | Direction | tdata fields (lowest bit up)
//  req     | in        | roll_deg, pitch_deg, yaw_deg (16 bits each)
//  rsp     | out       | row1_col1 .. row3_col3 (16 bits each, row-major)
//
// One angle triple enters per cycle unless rsp stalls; the pipeline runs through
// the reduction, two radian conversion stages, the CORDIC stages, the clamp
// and three product stages.
// Reset clears the valid bits of all stages.
// A stall on rsp freezes the whole pipeline; req_tready follows rsp_tready
// when the output holds a transfer, so nothing is lost or repeated.
module euler_to_rotation_matrix_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,  // roll_deg, pitch_deg, yaw_deg
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata   // row1_col1 .. row3_col3
);
   import e2r_pkg::*;

   localparam int Lat = CordicSteps + 7;

   logic [Lat-1:0] valid_ff;
   logic [Lat-1:0] valid_in;
   logic           en;
   sincos_type     sc_r, sc_p, sc_y;
   entry_type      entry [9];

   // The pipeline advances unless a held result waits.
   assign en         = !valid_ff[Lat-1] || rsp_tready;
   assign req_tready = en;
   assign valid_in   = {valid_ff[Lat-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (en) valid_ff <= valid_in;
   end

   e2r_sincos u_roll  (.clock, .en, .angle(angle_type'(req_tdata[15:0])),
                       .result(sc_r));
   e2r_sincos u_pitch (.clock, .en, .angle(angle_type'(req_tdata[31:16])),
                       .result(sc_p));
   e2r_sincos u_yaw   (.clock, .en, .angle(angle_type'(req_tdata[47:32])),
                       .result(sc_y));

   e2r_matrix u_matrix (.clock, .en, .roll(sc_r), .pitch(sc_p), .yaw(sc_y), .entry);

   assign rsp_tvalid = valid_ff[Lat-1];
   for (genvar k = 0; k < 9; k++) begin : g_pack
      assign rsp_tdata[16*k +: 16] = entry[k];
   end
endmodule

// File: hdl/e2r_checker.sv
// Port-level checker for the Euler to rotation block and its bind.
module e2r_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [143:0] rsp_tdata
);
   // A stalled result holds its data.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   // Input is ready whenever output is ready.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready) else $error("input stalled without backpressure");
   // No result right after reset.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
   // The row3 col1 entry stays within plus or minus one.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[111:96]) <= 16'sd16384 &&
                      $signed(rsp_tdata[111:96]) >= -16'sd16384))
      else $error("entry out of range");
endmodule

bind euler_to_rotation_matrix_top e2r_checker u_e2r_checker (.*);

// File: tb/sv/euler_to_rotation_matrix_top_tb.sv
// Testbench for the Euler angle to rotation matrix block: predicts each matrix and checks it.
`timescale 1ns / 100ps

module euler_to_rotation_matrix_top_tb;
   import e2r_pkg::*;

   localparam int NumRandom   = 1150;
   localparam int StallLimit  = 20000;
   localparam int DrainCycles = CordicSteps + 20;

   // Arctangent table in Q2.30, one entry for each i from 0 to 31; the CORDIC steps use the first entries.
   localparam longint AtanTable [32] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
      128, 64, 32, 16, 8, 4, 2, 1, 0};

   typedef logic [143:0] matrix_bits;

   // Scoreboard: predicts the matrix for each angle triple and compares results.
   class matrix_scoreboard;
      matrix_bits pending[$];
      int         fail_count = 0;

      // Floor shift right with rounding, half up.
      function automatic longint round_shift(longint v, int n);
         return (v + (longint'(1) <<< (n - 1))) >>> n;
      endfunction

      function automatic longint mul_q30(longint a, longint b);
         return round_shift(a * b, 30);
      endfunction

      function automatic longint clamp_one(longint v);
         if (v > 64'sd1073741824) return 64'sd1073741824;
         if (v < -64'sd1073741824) return -64'sd1073741824;
         return v;
      endfunction

      function automatic logic [15:0] entry_of(longint v);
         longint q;
         q = round_shift(v, 16);
         if (q > 16384) q = 16384;
         if (q < -16384) q = -16384;
         return q[15:0];
      endfunction

      // Cosine and sine of one angle in degrees (7 fraction bits).
      function automatic void angle_sincos(logic signed [15:0] raw,
                                           output longint c, output longint s);
         longint a, m, x, y, z, nx, t;
         bit     neg_s, neg_c;
         a = raw;
         neg_c = 0;
         if (a >= 23040) a -= 46080;
         if (a < -23040) a += 46080;
         neg_s = a < 0;
         m = neg_s ? -a : a;
         if (m > 11520) begin
            m = 23040 - m;
            neg_c = 1;
         end
         z = (m * 64'sd3373259426 + 11520) / 23040;
         x = 652032874;
         y = 0;
         for (int i = 0; i < CordicSteps; i++) begin
            t = AtanTable[i < 32 ? i : 31];
            if (z >= 0) begin
               nx = x - (y >>> i);
               y  = y + (x >>> i);
               z  = z - t;
            end else begin
               nx = x + (y >>> i);
               y  = y - (x >>> i);
               z  = z + t;
            end
            x = nx;
         end
         x = clamp_one(x);
         y = clamp_one(y);
         c = neg_c ? -x : x;
         s = neg_s ? -y : y;
      endfunction

      // Notes one accepted angle triple and queues its rotation matrix.
      function void note_angles(logic [47:0] angles);
         longint cr, sr, cp, sp, cy, sy, cysp, sysp;
         matrix_bits mat;
         angle_sincos(angles[15:0], cr, sr);
         angle_sincos(angles[31:16], cp, sp);
         angle_sincos(angles[47:32], cy, sy);
         cysp = mul_q30(cy, sp);
         sysp = mul_q30(sy, sp);
         mat[15:0]    = entry_of(mul_q30(cy, cp));
         mat[31:16]   = entry_of(mul_q30(cysp, sr) - mul_q30(sy, cr));
         mat[47:32]   = entry_of(mul_q30(cysp, cr) + mul_q30(sy, sr));
         mat[63:48]   = entry_of(mul_q30(sy, cp));
         mat[79:64]   = entry_of(mul_q30(sysp, sr) + mul_q30(cy, cr));
         mat[95:80]   = entry_of(mul_q30(sysp, cr) - mul_q30(cy, sr));
         mat[111:96]  = entry_of(-sp);
         mat[127:112] = entry_of(mul_q30(cp, sr));
         mat[143:128] = entry_of(mul_q30(cp, cr));
         pending.push_back(mat);
      endfunction

      // Checks one result transfer against the oldest predicted matrix.
      function void check_matrix(matrix_bits got);
         matrix_bits want;
         string names [9] = '{"row1_col1", "row1_col2", "row1_col3",
                              "row2_col1", "row2_col2", "row2_col3",
                              "row3_col1", "row3_col2", "row3_col3"};
         if (pending.size() == 0) begin
            $error("unexpected result transfer %h", got);
            fail_count++;
            return;
         end
         want = pending.pop_front();
         for (int k = 0; k < 9; k++) begin
            if (got[16*k +: 16] !== want[16*k +: 16]) begin
               $error("%s: expected %0d, actual %0d", names[k],
                      $signed(want[16*k +: 16]), $signed(got[16*k +: 16]));
               fail_count++;
            end
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [143:0] rsp_tdata;

   matrix_scoreboard board = new();
   int  idle_cycles = 0;
   bit  stalls_on = 1;

   euler_to_rotation_matrix_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Receiver stall pattern: long ready stretches, stall bursts and one clear run.
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (!stalls_on) begin
         rsp_tready <= 1;
      end else if (rsp_tready) begin
         rsp_tready <= (r >= 12);
      end else begin
         rsp_tready <= (r >= 55);
      end
   end

   // Result monitor and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_matrix(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= StallLimit) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Drives one angle triple and holds it until the transfer completes.
   task automatic send_angles(logic [47:0] angles);
      req_tvalid <= 1;
      req_tdata  <= angles;
      do @(posedge clock); while (!req_tready);
      board.note_angles(angles);
   endtask

   task automatic drop_valid(int gap);
      if (gap > 0) begin
         req_tvalid <= 0;
         req_tdata  <= {$urandom, $urandom};
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] pick_angle();
      logic [15:0] special [12] = '{16'h0000, 16'h7FFF, 16'h8000, 16'd23040,
                                    -16'sd23040, 16'd11520, -16'sd11520,
                                    16'd11521, 16'd23039, 16'd1, 16'hFFFF,
                                    16'd46080 - 16'd23040};
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return special[$urandom_range(0, 11)];
      if (r == 1) return 16'($urandom_range(0, 46080) - 23040);
      return 16'($urandom);
   endfunction

   initial begin
      logic [15:0] directed [12] = '{16'h0000, 16'h7FFF, 16'h8000, 16'd23040,
                                     -16'sd23040, 16'd11520, -16'sd11520,
                                     16'd11521, 16'd5760, 16'd1, 16'hFFFF,
                                     16'd30000};
      int burst, sent;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: extremes, quarter and half turns, minus half-turn.
      for (int k = 0; k < 12; k++)
         send_angles({directed[(k + 7) % 12], directed[(k + 3) % 12], directed[k]});
      for (int k = 0; k < 6; k++)
         send_angles({directed[k], directed[k], directed[k]});
      drop_valid(1);

      // Hold off until every queued matrix has come back.
      wait (board.pending.size() == 0);
      @(posedge clock);

      // Random part in bursts with random gaps; one run without receiver stalls.
      sent = 0;
      while (sent < NumRandom) begin
         burst = $urandom_range(1, 40);
         stalls_on = !(sent >= 400 && sent < 520);
         for (int k = 0; k < burst && sent < NumRandom; k++) begin
            send_angles({pick_angle(), pick_angle(), pick_angle()});
            sent++;
         end
         drop_valid($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
      end
      drop_valid(1);
      stalls_on = 1;

      wait (board.pending.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      if (board.fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
